/* rtl/stpc_pkg.sv */
// ----------------------------------------------------------------------------
// stpc_pkg
// Shared types and constants of the servo teach and playback controller.
// ----------------------------------------------------------------------------
package stpc_pkg;

    localparam int DEF_SLOT_COUNT = 4;
    localparam int SERVO_COUNT    = 4;

    // Item kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_BUTTON = 2'd1;
    localparam logic [1:0] KIND_UART   = 2'd2;

    // Operating modes
    localparam logic [1:0] MODE_MANUAL = 2'd0;
    localparam logic [1:0] MODE_MEMORY = 2'd1;
    localparam logic [1:0] MODE_REMOTE = 2'd2;

    // Serial frame characters
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] CHAN_FIRST = 8'h31;
    localparam logic [7:0] CHAN_LAST  = 8'h34;
    localparam logic [7:0] WEIGHT_HUNDREDS = 8'd100;
    localparam logic [7:0] WEIGHT_TENS     = 8'd10;

    // Remote positions after reset, servo one in the low byte
    localparam logic [3:0][7:0] REMOTE_RESET = {8'd193, 8'd196, 8'd148, 8'd135};

    // Erased store content
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] sample_channel;
        logic [7:0] sample_value;
        logic       mode_button;
        logic       store_button;
        logic [7:0] rx_byte;
    } stpc_in_t;

    typedef struct packed {
        logic [7:0] drive_one;
        logic [7:0] drive_two;
        logic [7:0] drive_three;
        logic [7:0] drive_four;
        logic [1:0] mode;
        logic [1:0] slot_pointer;
    } stpc_out_t;

    // Decoded event strobes, each qualified by the pipeline advance
    typedef struct packed {
        logic sample_en;
        logic button_en;
        logic uart_en;
    } stpc_evt_t;

endpackage

/* rtl/stpc_uart_frame.sv */
// ----------------------------------------------------------------------------
// stpc_uart_frame
// Four-byte serial frame decoder that sets the remote servo positions.
// ----------------------------------------------------------------------------
module stpc_uart_frame (
    input  logic                clk,
    input  logic                rst_n,
    input  stpc_pkg::stpc_evt_t evt,
    input  logic [7:0]          rx_byte,
    output logic [3:0][7:0]     remote_next
);
    import stpc_pkg::*;

    typedef enum logic [1:0] {
        PHASE_CHANNEL,
        PHASE_HUNDREDS,
        PHASE_TENS,
        PHASE_UNITS
    } phase_t;

    phase_t          phase_reg;
    phase_t          phase_next;
    logic [7:0]      chan_reg;
    logic [7:0]      chan_next;
    logic [7:0]      hund_reg;
    logic [7:0]      hund_next;
    logic [7:0]      tens_reg;
    logic [7:0]      tens_next;
    logic [3:0][7:0] remote_reg;
    logic [7:0]      digit;
    logic [15:0]     hund_prod;
    logic [15:0]     tens_prod;
    logic [7:0]      value;
    logic [7:0]      chan_off;

    assign digit     = rx_byte - ASCII_ZERO;
    assign hund_prod = {8'd0, digit} * {8'd0, WEIGHT_HUNDREDS};
    assign tens_prod = {8'd0, digit} * {8'd0, WEIGHT_TENS};
    assign value     = hund_reg + tens_reg + digit;
    assign chan_off  = chan_reg - CHAN_FIRST;

    always_comb
    begin
        phase_next  = phase_reg;
        chan_next   = chan_reg;
        hund_next   = hund_reg;
        tens_next   = tens_reg;
        remote_next = remote_reg;
        if (evt.uart_en)
        begin
            case (phase_reg)
                PHASE_CHANNEL:
                begin
                    chan_next  = rx_byte;
                    phase_next = PHASE_HUNDREDS;
                end
                PHASE_HUNDREDS:
                begin
                    hund_next  = hund_prod[7:0];
                    phase_next = PHASE_TENS;
                end
                PHASE_TENS:
                begin
                    tens_next  = tens_prod[7:0];
                    phase_next = PHASE_UNITS;
                end
                default:
                begin
                    // drop frames with an unknown channel character
                    if (chan_reg >= CHAN_FIRST && chan_reg <= CHAN_LAST)
                    begin
                        remote_next[chan_off[1:0]] = value;
                    end
                    phase_next = PHASE_CHANNEL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PHASE_CHANNEL;
            chan_reg   <= '0;
            hund_reg   <= '0;
            tens_reg   <= '0;
            remote_reg <= REMOTE_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            chan_reg   <= chan_next;
            hund_reg   <= hund_next;
            tens_reg   <= tens_next;
            remote_reg <= remote_next;
        end
    end

endmodule

/* rtl/stpc_teach.sv */
// ----------------------------------------------------------------------------
// stpc_teach
// Mode sequencing, live positions and the slot store for teach and playback.
// ----------------------------------------------------------------------------
module stpc_teach #(
    parameter int SLOT_COUNT = stpc_pkg::DEF_SLOT_COUNT,
    parameter int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  stpc_pkg::stpc_evt_t evt,
    input  stpc_pkg::stpc_in_t  item,
    output logic [3:0][7:0]     live_next,
    output logic [1:0]          mode_next,
    output logic [SLOT_W-1:0]   slot_next
);
    import stpc_pkg::*;

    logic [1:0]            mode_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_mid;
    logic [SLOT_W-1:0]     slot_adv;
    logic [3:0][7:0]       live_reg;
    logic [3:0][7:0]       store_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] written_reg;
    logic [3:0][7:0]       row_rd;
    logic                  store_we;

    assign slot_adv = (slot_mid == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot_mid + 1'b1;
    // an erased slot reads back as all ones
    assign row_rd   = written_reg[slot_mid] ? store_reg[slot_mid] : {4{ERASED_BYTE}};

    always_comb
    begin
        mode_next = mode_reg;
        slot_mid  = slot_reg;
        live_next = live_reg;
        store_we  = 1'b0;
        if (evt.sample_en && mode_reg == MODE_MANUAL)
        begin
            live_next[item.sample_channel] = item.sample_value;
        end
        if (evt.button_en && item.mode_button)
        begin
            case (mode_reg)
                MODE_MANUAL:
                begin
                    mode_next = MODE_MEMORY;
                    slot_mid  = '0;
                end
                MODE_MEMORY:
                begin
                    mode_next = MODE_REMOTE;
                    slot_mid  = '0;
                end
                default:
                begin
                    mode_next = MODE_MANUAL;
                end
            endcase
        end
        slot_next = slot_mid;
        // store action follows the mode held before this event
        if (evt.button_en && item.store_button)
        begin
            if (mode_reg == MODE_MANUAL)
            begin
                store_we  = 1'b1;
                slot_next = slot_adv;
            end
            else if (mode_reg == MODE_MEMORY)
            begin
                live_next = row_rd;
                slot_next = slot_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_MANUAL;
            slot_reg    <= '0;
            live_reg    <= '0;
            written_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            slot_reg <= slot_next;
            live_reg <= live_next;
            if (store_we)
            begin
                written_reg[slot_mid] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[slot_mid] <= live_reg;
        end
    end

endmodule

/* rtl/servo_teach_playback_controller_top.sv */
// ----------------------------------------------------------------------------
// servo_teach_playback_controller_top
// Four-servo teach and playback controller with manual, memory and remote modes.
// ----------------------------------------------------------------------------
// Takes one item (adc sample, button event or serial byte) per clock and
// returns one result per item: the four servo drive values for the mode in
// force after the item, the mode and the slot pointer. An item is held first
// in the input register and then in the result register;
// the whole state update is a single pass of logic between the two, so a new
// transfer is taken every cycle while the result side keeps up. The slot
// store is held in flip-flops with one erased flag per slot, so it is ready
// right after reset with no clearing pass.
module servo_teach_playback_controller_top #(
    parameter int SLOT_COUNT = stpc_pkg::DEF_SLOT_COUNT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  stpc_pkg::stpc_in_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output stpc_pkg::stpc_out_t result
);
    import stpc_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    stpc_in_t          in_item_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    stpc_out_t         out_reg;
    stpc_out_t         out_next;
    logic              advance;
    logic              accept;
    stpc_evt_t         evt;
    logic [3:0][7:0]   live_next;
    logic [3:0][7:0]   remote_next;
    logic [3:0][7:0]   drive;
    logic [1:0]        mode_next;
    logic [SLOT_W-1:0] slot_next;
    logic [SLOT_W+1:0] slot_ext;

    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    assign evt.sample_en = advance && in_item_reg.kind == KIND_SAMPLE;
    assign evt.button_en = advance && in_item_reg.kind == KIND_BUTTON;
    assign evt.uart_en   = advance && in_item_reg.kind == KIND_UART;

    stpc_teach #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_teach (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .item      (in_item_reg),
        .live_next (live_next),
        .mode_next (mode_next),
        .slot_next (slot_next)
    );

    stpc_uart_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt         (evt),
        .rx_byte     (in_item_reg.rx_byte),
        .remote_next (remote_next)
    );

    assign drive    = (mode_next == MODE_REMOTE) ? remote_next : live_next;
    assign slot_ext = {2'b00, slot_next};

    always_comb
    begin
        out_next.drive_one    = drive[0];
        out_next.drive_two    = drive[1];
        out_next.drive_three  = drive[2];
        out_next.drive_four   = drive[3];
        out_next.mode         = mode_next;
        out_next.slot_pointer = slot_ext[1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= item;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> in_valid_reg && out_valid_reg && result_stall)
        else $error("input stalled without a held item and a stalled result");

    a_result_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result appeared without an item passing through");

    a_mode_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.mode == MODE_MANUAL || out_reg.mode == MODE_MEMORY
                           || out_reg.mode == MODE_REMOTE))
        else $error("result carries an unreachable mode");

    a_result_kept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_stall |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result was lost or changed");
`endif

endmodule
